FILE: rtl/ppp_pkg.sv
// Shared codes, field widths and flag types for the perspective point projection block.
// No dependencies.
package ppp_pkg;

   // command codes carried in req_tuser
   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_PROJECT = 1'b1;

   // register indexes on the csr port
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 8'd1;

   // fixed field widths
   localparam int COORD_W      = 32;
   localparam int SIZE_W       = 14;
   localparam int PIX_W        = 16;
   localparam int IDX_W        = 4;
   localparam int RATIO_INT_W  = 18;
   localparam int REQ_DATA_W   = 136;
   localparam int RSP_DATA_W   = 32;

   localparam logic [SIZE_W-1:0] WIDTH_RESET  = 14'd1080;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = 14'd1920;

   // per-beat flags riding beside the divider pipeline
   typedef struct packed {
      logic valid;
      logic visible;
      logic neg_x;
      logic neg_y;
      logic ovf_x;
      logic ovf_y;
   } flag_type;

endpackage

FILE: rtl/perspective_point_projection.sv
// Perspective point projection: 4x4 view matrix transform, w test, divide, viewport map.
// A project beat passes the product and sum stages, the queue, the sign split, the dividers, offset, scale and result.
// Throughput one beat per cycle while rsp_tready does not stall; the dividers retire one quotient bit per stage.
// Load beats write the matrix and give no result. Synchronous active-high reset clears the
// matrix to zero, sets width 1080 and height 1920, and empties all stages.
// Depends on ppp_pkg, ppp_front, ppp_queue, ppp_div, ppp_back.
module perspective_point_projection
   import ppp_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // coef_index[3:0], coef_value[35:4], point_x[67:36], point_y[99:68],
   // point_z[131:100], zero pad
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // cmd
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // screen_x[15:0], screen_y[31:16]
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // visible
   output logic                   rsp_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [SIZE_W-1:0]      csr_data
);

   localparam int SUM_W = 66 - FRAC_BITS;

   logic                 push, pop, q_full, q_empty;
   logic [3*SUM_W-1:0]   push_data, q_data;

   assign csr_ready = 1'b1;

   ppp_front #(.FRAC_BITS(FRAC_BITS), .SUM_W(SUM_W)) u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .push(push), .push_data(push_data), .q_full(q_full));

   ppp_queue #(.WIDTH(3*SUM_W), .DEPTH(4)) u_queue (
      .clock(clock), .reset(reset),
      .push(push), .wr_data(push_data),
      .pop(pop), .rd_data(q_data),
      .full(q_full), .empty(q_empty));

   ppp_back #(.FRAC_BITS(FRAC_BITS), .SUM_W(SUM_W)) u_back (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_data(csr_data),
      .q_empty(q_empty), .q_data(q_data), .pop(pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser));

endmodule

FILE: rtl/ppp_front.sv
// Front end: accepts beats, holds the view matrix, forms the X, Y and w sums.
// Depends on ppp_pkg.
module ppp_front
   import ppp_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int SUM_W     = 66 - FRAC_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // coef_index, coef_value, point_x, point_y, point_z, zero pad
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   // cmd
   input  logic                    req_tuser,
   output logic                    push,
   output logic [3*SUM_W-1:0]      push_data,
   input  logic                    q_full
);

   localparam int PROD_W = 2*COORD_W - FRAC_BITS;

   logic                      en;
   logic                      acc;
   logic [IDX_W-1:0]          coef_index;
   logic signed [COORD_W-1:0] coef_value;
   logic signed [COORD_W-1:0] pt [3];

   logic signed [COORD_W-1:0] mat_ff [16];
   logic                      s1_valid_ff, s2_valid_ff;
   logic signed [PROD_W-1:0]  prod_ff [3][3];
   logic signed [COORD_W-1:0] const_ff [3];
   logic signed [SUM_W-1:0]   sum_ff [3];
   logic signed [SUM_W-1:0]   sum_in [3];

   assign coef_index = req_tdata[3:0];
   assign coef_value = req_tdata[35:4];
   assign pt[0]      = req_tdata[67:36];
   assign pt[1]      = req_tdata[99:68];
   assign pt[2]      = req_tdata[131:100];

   // stall only when the last stage holds a beat the queue cannot take
   assign en         = !(s2_valid_ff && q_full);
   assign req_tready = en;
   assign acc        = req_tvalid && en;

   // matrix store, written by load beats
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) mat_ff[i] <= '0;
      end else if (acc && req_tuser == CMD_LOAD) begin
         mat_ff[coef_index] <= coef_value;
      end
   end

   // stage 1: products, floored to Q.F (upper bits of the full product)
   for (genvar r = 0; r < 3; r++) begin : g_row
      localparam int ROW = (r == 2) ? 3 : r;
      for (genvar c = 0; c < 3; c++) begin : g_col
         logic signed [2*COORD_W-1:0] p;
         assign p = mat_ff[c*4 + ROW] * pt[c];
         always_ff @(posedge clock) begin
            if (en) prod_ff[r][c] <= p[2*COORD_W-1:FRAC_BITS];
         end
      end
      always_ff @(posedge clock) begin
         if (en) const_ff[r] <= mat_ff[12 + ROW];
      end
      // stage 2: exact sums
      always_comb begin
         sum_in[r] = SUM_W'(prod_ff[r][0]) + SUM_W'(prod_ff[r][1])
                   + SUM_W'(prod_ff[r][2]) + SUM_W'(const_ff[r]);
      end
      always_ff @(posedge clock) begin
         if (en) sum_ff[r] <= sum_in[r];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= acc && req_tuser == CMD_PROJECT;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   assign push      = s2_valid_ff && !q_full;
   assign push_data = {sum_ff[2], sum_ff[1], sum_ff[0]};

endmodule

FILE: rtl/ppp_queue.sv
// Small register FIFO between front and back ends.
// Depends on ppp_pkg.
module ppp_queue
   import ppp_pkg::*;
#(
   parameter int WIDTH = 150,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [PTR_W:0]   count_ff;

   assign full    = count_ff == (PTR_W+1)'(DEPTH);
   assign empty   = count_ff == '0;
   assign rd_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= wr_data;
   end

   // pointers wrap at the depth
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
         if (pop)  rd_ff <= (rd_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
         count_ff <= count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("queue pop while empty");
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (push == pop) |=> $stable(count_ff))
      else $error("queue count moved without net traffic");

endmodule

FILE: rtl/ppp_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on ppp_pkg.
module ppp_div
   import ppp_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int SUM_W     = 66 - FRAC_BITS,
   parameter int QB        = RATIO_INT_W + FRAC_BITS
) (
   input  logic             clock,
   input  logic             en,
   input  logic [SUM_W-1:0] num,
   input  logic [SUM_W-1:0] den,
   output logic [QB-1:0]    quo
);

   localparam int NUM_W = SUM_W + FRAC_BITS;
   localparam int CW    = SUM_W + QB;

   logic [NUM_W-1:0] rem_ff [QB];
   logic [SUM_W-1:0] den_ff [QB];
   logic [QB-1:0]    quo_ff [QB];

   for (genvar s = 0; s < QB; s++) begin : g_stage
      localparam int K = QB - 1 - s;
      logic [NUM_W-1:0] rem_src;
      logic [SUM_W-1:0] den_src;
      logic [QB-1:0]    quo_src;
      logic [CW-1:0]    dsh, rext, diff;
      logic             take;

      if (s == 0) begin : g_first
         assign rem_src = {num, {FRAC_BITS{1'b0}}};
         assign den_src = den;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign den_src = den_ff[s-1];
         assign quo_src = quo_ff[s-1];
      end

      // trial subtract of den shifted to this bit
      assign dsh  = CW'(den_src) << K;
      assign rext = CW'(rem_src);
      assign diff = rext - dsh;
      assign take = rext >= dsh;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= take ? diff[NUM_W-1:0] : rem_src;
            den_ff[s] <= den_src;
            quo_ff[s] <= quo_src | (QB'(take) << K);
         end
      end
   end

   assign quo = quo_ff[QB-1];

endmodule

FILE: rtl/ppp_back.sv
// Back end: visibility test, two ratio dividers, viewport mapping, result register.
// Depends on ppp_pkg and ppp_div.
module ppp_back
   import ppp_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int SUM_W     = 66 - FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [SIZE_W-1:0]      csr_data,
   input  logic                   q_empty,
   input  logic [3*SUM_W-1:0]     q_data,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic                   rsp_tuser
);

   localparam int QB    = RATIO_INT_W + FRAC_BITS;
   localparam int TW    = QB + 3;
   localparam int PW    = TW + SIZE_W + 1;
   localparam int SH    = FRAC_BITS + 1;
   localparam logic signed [SUM_W-1:0] W_MIN = SUM_W'(((1 << FRAC_BITS) + 50) / 100);
   localparam logic signed [TW-1:0]    ONE_Q = TW'(1) << FRAC_BITS;
   localparam logic signed [PW-1:0]    PIX_MAX = PW'(32767);
   localparam logic signed [PW-1:0]    PIX_MIN = -PW'(32768);

   logic en;
   logic [SIZE_W-1:0] width_ff, height_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  width_ff  <= csr_data;
            CSR_SCREEN_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // whole back pipeline advances when the result register can move
   assign en  = !rsp_tvalid || rsp_tready;
   assign pop = en && !q_empty;

   // stage A: sign split and clamp detection
   logic signed [SUM_W-1:0] sx, sy, sw;
   logic [SUM_W-1:0]        nx_in, ny_in, d_in;
   logic                    vis_in;
   flag_type                fa_in;
   logic [SUM_W-1:0]        nx_ff, ny_ff, d_ff;
   flag_type                fa_ff;

   assign sx     = q_data[SUM_W-1:0];
   assign sy     = q_data[2*SUM_W-1:SUM_W];
   assign sw     = q_data[3*SUM_W-1:2*SUM_W];
   assign vis_in = sw >= W_MIN;
   assign nx_in  = sx[SUM_W-1] ? SUM_W'(-sx) : SUM_W'(sx);
   assign ny_in  = sy[SUM_W-1] ? SUM_W'(-sy) : SUM_W'(sy);
   assign d_in   = vis_in ? SUM_W'(sw) : SUM_W'(1);

   always_comb begin
      fa_in.valid   = pop;
      fa_in.visible = vis_in;
      fa_in.neg_x   = sx[SUM_W-1];
      fa_in.neg_y   = sy[SUM_W-1];
      fa_in.ovf_x   = {{RATIO_INT_W{1'b0}}, nx_in} >= {d_in, {RATIO_INT_W{1'b0}}};
      fa_in.ovf_y   = {{RATIO_INT_W{1'b0}}, ny_in} >= {d_in, {RATIO_INT_W{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) fa_ff <= '0;
      else if (en) fa_ff <= fa_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nx_ff <= nx_in;
         ny_ff <= ny_in;
         d_ff  <= d_in;
      end
   end

   // dividers and the matching flag line
   logic [QB-1:0] qx, qy;
   flag_type      fl_ff [QB];

   ppp_div #(.FRAC_BITS(FRAC_BITS), .SUM_W(SUM_W), .QB(QB)) u_div_x (
      .clock(clock), .en(en), .num(nx_ff), .den(d_ff), .quo(qx));
   ppp_div #(.FRAC_BITS(FRAC_BITS), .SUM_W(SUM_W), .QB(QB)) u_div_y (
      .clock(clock), .en(en), .num(ny_ff), .den(d_ff), .quo(qy));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QB; i++) fl_ff[i] <= '0;
      end else if (en) begin
         fl_ff[0] <= fa_ff;
         for (int i = 1; i < QB; i++) fl_ff[i] <= fl_ff[i-1];
      end
   end

   // stage B: signed ratio added to one (x) or taken from one (y); overflowed ratios clamp to 2^18
   flag_type               fb_ff;
   logic signed [TW-1:0]   mx, my, tx_in, ty_in, tx_ff, ty_ff;
   flag_type               fq;

   assign fq    = fl_ff[QB-1];
   assign mx    = fq.ovf_x ? (TW'(1) << QB) : TW'(qx);
   assign my    = fq.ovf_y ? (TW'(1) << QB) : TW'(qy);
   assign tx_in = ONE_Q + (fq.neg_x ? -mx : mx);
   assign ty_in = ONE_Q - (fq.neg_y ? -my : my);

   always_ff @(posedge clock) begin
      if (en) begin
         tx_ff <= tx_in;
         ty_ff <= ty_in;
      end
   end

   // stage C: scale by viewport size
   flag_type             fc_ff;
   logic signed [PW-1:0] px_ff, py_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= PW'(tx_ff) * $signed({1'b0, width_ff});
         py_ff <= PW'(ty_ff) * $signed({1'b0, height_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_ff <= '0;
         fc_ff <= '0;
      end else if (en) begin
         fb_ff <= fq;
         fc_ff <= fb_ff;
      end
   end

   // stage D: truncate toward zero, saturate, result register
   logic signed [PW-1:0]    shx, shy;
   logic signed [PIX_W-1:0] pixx, pixy;

   assign shx = (px_ff + (px_ff[PW-1] ? PW'((1 << SH) - 1) : PW'(0))) >>> SH;
   assign shy = (py_ff + (py_ff[PW-1] ? PW'((1 << SH) - 1) : PW'(0))) >>> SH;

   always_comb begin
      if (shx > PIX_MAX)      pixx = PIX_W'(PIX_MAX);
      else if (shx < PIX_MIN) pixx = PIX_W'(PIX_MIN);
      else                    pixx = PIX_W'(shx);
      if (shy > PIX_MAX)      pixy = PIX_W'(PIX_MAX);
      else if (shy < PIX_MIN) pixy = PIX_W'(PIX_MIN);
      else                    pixy = PIX_W'(shy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (en) begin
         rsp_tvalid <= fc_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tuser <= fc_ff.visible;
         rsp_tdata <= fc_ff.visible ? {pixy, pixx} : '0;
      end
   end

   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("rejected point with nonzero pixels");
   a_pop_gated: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !pop)
      else $error("queue popped while result stalled");
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

FILE: bench/ppp_checker.sv
`timescale 1ns / 100ps
// Checker for perspective_point_projection: watches the req, rsp and csr channels, predicts
// each projection result from its own matrix and viewport copy, and compares. Needs ppp_pkg.
module ppp_checker
   import ppp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [SIZE_W-1:0]     csr_data,
   output int                    errors,
   output int                    pending,
   output int                    shown_count,
   output int                    hidden_count
);

   localparam int  FRAC = 16;
   localparam longint W_FLOOR = ((longint'(1) << FRAC) + 50) / 100;
   localparam longint ONE = longint'(1) << FRAC;

   typedef struct packed {
      logic              visible;
      logic signed [15:0] px;
      logic signed [15:0] py;
   } pixel_type;

   logic signed [31:0] matrix [16];
   logic [SIZE_W-1:0]  view_w, view_h;
   pixel_type          expected_pixels [$];

   // coef * coord, floored back to Q16.16
   function automatic longint mul_floor(logic signed [31:0] a, logic signed [31:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return p >>> FRAC;
   endfunction

   // num / den in Q16.16, truncated toward zero, magnitude clamped (den > 0)
   function automatic longint div_clamp(longint num, longint den);
      logic   neg;
      longint n, qi, rem, frac, mag;
      neg = num < 0;
      n = neg ? -num : num;
      qi = n / den;
      rem = n % den;
      frac = 0;
      if (qi >= (longint'(1) << RATIO_INT_W)) begin
         mag = longint'(1) << (RATIO_INT_W + FRAC);
      end else begin
         for (int i = 0; i < FRAC; i++) begin
            rem = rem << 1;
            frac = frac << 1;
            if (rem >= den) begin
               rem = rem - den;
               frac = frac | 1;
            end
         end
         mag = (qi << FRAC) | frac;
      end
      return neg ? -mag : mag;
   endfunction

   // viewport map: truncate toward zero, saturate to 16-bit signed
   function automatic logic signed [15:0] map_axis(longint t, logic [SIZE_W-1:0] size);
      longint p;
      p = t * longint'(size);
      p = (p >= 0) ? (p >>> (FRAC + 1)) : -((-p) >>> (FRAC + 1));
      if (p > 32767) p = 32767;
      if (p < -32768) p = -32768;
      return p[15:0];
   endfunction

   function automatic pixel_type project(logic signed [31:0] x, logic signed [31:0] y,
                                         logic signed [31:0] z);
      pixel_type r;
      longint    w, sx, sy;
      r = '0;
      w = mul_floor(matrix[3], x) + mul_floor(matrix[7], y) + mul_floor(matrix[11], z)
          + longint'(matrix[15]);
      if (w < W_FLOOR) return r;
      sx = mul_floor(matrix[0], x) + mul_floor(matrix[4], y) + mul_floor(matrix[8], z)
           + longint'(matrix[12]);
      sy = mul_floor(matrix[1], x) + mul_floor(matrix[5], y) + mul_floor(matrix[9], z)
           + longint'(matrix[13]);
      r.visible = 1'b1;
      r.px = map_axis(div_clamp(sx, w) + ONE, view_w);
      r.py = map_axis(ONE - div_clamp(sy, w), view_h);
      return r;
   endfunction

   task automatic report(string what, int got, int want);
      $display("ppp_checker: %0t %s mismatch: got %0d expected %0d", $time, what, got, want);
      errors++;
   endtask

   assign pending = expected_pixels.size();

   initial begin
      errors = 0;
      shown_count = 0;
      hidden_count = 0;
   end

   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         foreach (matrix[i]) matrix[i] = '0;
         view_w = WIDTH_RESET;
         view_h = HEIGHT_RESET;
         expected_pixels.delete();
      end else begin
         // register writes; unknown indexes are ignored
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SCREEN_WIDTH) view_w = csr_data;
            else if (csr_index == CSR_SCREEN_HEIGHT) view_h = csr_data;
         end
         // result beat against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               $display("ppp_checker: %0t result beat with nothing expected", $time);
               errors++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_tuser !== want.visible) report("visible", rsp_tuser, want.visible);
               if (rsp_tdata[15:0] !== want.px)
                  report("screen_x", $signed(rsp_tdata[15:0]), want.px);
               if (rsp_tdata[31:16] !== want.py)
                  report("screen_y", $signed(rsp_tdata[31:16]), want.py);
               if (want.visible) shown_count++;
               else hidden_count++;
            end
         end
         // input beat: load a coefficient or queue a projection
         if (req_tvalid && req_tready) begin
            if (req_tuser == CMD_LOAD)
               matrix[req_tdata[3:0]] = req_tdata[35:4];
            else
               expected_pixels.push_back(project(req_tdata[67:36], req_tdata[99:68],
                                                 req_tdata[131:100]));
         end
      end
   end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Top of the perspective_point_projection bench: clock, reset, load/project stimulus,
// viewport register phases and the verdict. Needs ppp_pkg, ppp_checker and the RTL.
module tb_top;
   import ppp_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 60;
   localparam int ITEMS_PER_PHASE = 210;

   logic                  clock, reset;
   logic                  req_tvalid, req_tready, req_tuser;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid, rsp_tready, rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [SIZE_W-1:0]     csr_data;
   int                    errors, pending, shown_count, hidden_count;
   int                    burst_left, idle_count;
   bit                    hold_req;

   perspective_point_projection dut (.*);

   ppp_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // input beat: random gaps between bursts, data packed z/y/x/value/index from the top down
   task automatic send(logic cmd, logic [3:0] idx, logic [31:0] val,
                       logic [31:0] x, logic [31:0] y, logic [31:0] z);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0, z, y, x, val, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // drop valid, drain, and let any trailing load beats retire
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mix of full-range, moderate and extreme Q16.16 values
   function automatic logic [31:0] pick_q();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h7fff_ffff;
         2: return 32'h8000_0000;
         3: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 20)
                                         : -$urandom_range(0, 1 << 20);
         default: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 18)
                                               : -$urandom_range(0, 1 << 18);
      endcase
   endfunction

   // receiver: stall pattern changes every stretch, one long hold on request
   initial begin
      int mode;
      rsp_tready = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         if (hold_req) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_req = 0;
         end
         repeat ($urandom_range(16, 80)) begin
            @(negedge clock);
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= $urandom_range(0, 1);
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // watchdog: cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_count <= 0;
      end else begin
         idle_count <= idle_count + 1;
         if (idle_count >= WATCHDOG_LIMIT) begin
            $display("tb_top: watchdog expired, %0d results outstanding", pending);
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   initial begin
      logic [3:0]  idx;
      logic [31:0] val;
      logic [13:0] sizes_w [5];
      logic [13:0] sizes_h [5];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = CMD_LOAD;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      burst_left = 0;
      idle_count = 0;
      hold_req = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: default viewport, simple perspective (w = z)
      send(CMD_PROJECT, 4'd9, 32'h1234, 32'h1_0000, 0, 32'h1_0000);   // all-zero matrix
      send(CMD_LOAD, 4'd0, 32'h1_0000, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      send(CMD_LOAD, 4'd5, 32'h1_0000, 0, 0, 0);
      send(CMD_LOAD, 4'd11, 32'h1_0000, 0, 0, 0);
      send(CMD_PROJECT, 4'hf, 32'hffff_ffff, 0, 0, 32'd655);           // w at threshold
      send(CMD_PROJECT, 4'd0, 0, 0, 0, 32'd654);                        // just below
      send(CMD_PROJECT, 4'd0, 0, 32'h1_0000, 32'hffff_0000, 32'h0);
      send(CMD_PROJECT, 4'd0, 0, 32'h2_0000, 32'h3_0000, 32'hfffe_0000);
      send(CMD_PROJECT, 4'd0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'd655);  // huge ratios
      send(CMD_PROJECT, 4'd0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'd700);
      send(CMD_PROJECT, 4'd0, 0, 32'h8000, 32'hffff_8000, 32'h1_0000);
      send(CMD_PROJECT, 4'd0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send(CMD_LOAD, 4'd15, 32'h7fff_ffff, 0, 0, 0);
      send(CMD_LOAD, 4'd3, 32'h8000_0000, 0, 0, 0);
      send(CMD_PROJECT, 4'd0, 0, 32'h8000_0000, 0, 0);
      send(CMD_PROJECT, 4'd0, 0, 32'h7fff_ffff, 32'h1_0000, 32'h8000_0000);
      send(CMD_LOAD, 4'd12, 32'h8000_0000, 0, 0, 0);
      send(CMD_LOAD, 4'd13, 32'h7fff_ffff, 0, 0, 0);
      send(CMD_PROJECT, 4'd0, 0, 0, 0, 0);
      settle();

      // viewport phases: extremes, zero size, odd sizes
      sizes_w = '{14'd1, 14'd8192, 14'd0, 14'd640, 14'd1080};
      sizes_h = '{14'd1, 14'd8192, 14'd0, 14'd480, 14'd1920};
      for (int ph = 0; ph < 5; ph++) begin
         if (ph == 4) begin
            sizes_w[ph] = 14'($urandom_range(1, 8192));
            sizes_h[ph] = 14'($urandom_range(1, 8192));
         end
         write_reg(CSR_SCREEN_WIDTH, sizes_w[ph]);
         write_reg(CSR_SCREEN_HEIGHT, sizes_h[ph]);
         // unknown index, ignored
         write_reg(CSR_IDX_W'(2 + $urandom_range(0, 200)), SIZE_W'($urandom()));
         if (ph == 1) hold_req = 1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 9) < 3) begin
               idx = 4'($urandom());
               val = pick_q();
               // keep w usually positive so most points pass the threshold
               if (idx == 4'd15 && $urandom_range(0, 3) != 0) val[31] = 1'b0;
               send(CMD_LOAD, idx, val, $urandom(), $urandom(), $urandom());
            end else begin
               send(CMD_PROJECT, 4'($urandom()), $urandom(), pick_q(), pick_q(), pick_q());
            end
         end
         settle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("tb_top: directed plus %0d random beats over 5 viewport settings",
               5 * ITEMS_PER_PHASE);
      $display("tb_top: %0d visible and %0d rejected points checked", shown_count,
               hidden_count);
      if (errors == 0 && pending == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/ppp_pkg.sv
rtl/ppp_front.sv
rtl/ppp_queue.sv
rtl/ppp_div.sv
rtl/ppp_back.sv
rtl/perspective_point_projection.sv
bench/ppp_checker.sv
bench/tb_top.sv
